### hw/rtl/plpt_pkg.sv
// ---------------------------------------------------------------------------
// Plugboard pair table package
// Action codes, the empty slot marker and the structs that run between the
// cells of the pair chain.
// ---------------------------------------------------------------------------
package plpt_pkg;

    localparam int LETTER_W = 8;
    localparam int COUNT_W  = 4;

    // action codes
    localparam logic [1:0] ACT_ADD  = 2'd0;
    localparam logic [1:0] ACT_DEL  = 2'd1;
    localparam logic [1:0] ACT_PERM = 2'd2;

    // value of a slot that holds no pair
    localparam logic [LETTER_W-1:0] EMPTY_MARK = 8'h2D;

    typedef logic [LETTER_W-1:0] t_letter;

    // broadcast to every cell for the item being accepted
    typedef struct packed {
        logic    add_en;
        logic    del_en;
        t_letter letter_a;
        t_letter letter_b;
    } t_ctrl;

    // handed from a cell to the next higher cell
    typedef struct packed {
        logic    used;
        logic    conflict;
        logic    del_seen;
        logic    perm_found;
        t_letter perm_letter;
    } t_chain;

    // contents of a cell, handed down to the next lower cell
    typedef struct packed {
        logic    used;
        t_letter first;
        t_letter second;
    } t_slot;

endpackage

### hw/rtl/plpt_ifs.sv
// ---------------------------------------------------------------------------
// Plugboard pair table channels
// Valid/ready channels for action items in and result items out.
// ---------------------------------------------------------------------------
interface plpt_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] action;
    logic [7:0] letter_a;
    logic [7:0] letter_b;

    modport source (output valid, output action, output letter_a, output letter_b,
                    input ready);
    modport sink   (input valid, input action, input letter_a, input letter_b,
                    output ready);
endinterface

interface plpt_out_if;
    logic       valid;
    logic       ready;
    logic       success;
    logic [7:0] letter_out;
    logic [3:0] pairs_in_use;

    modport source (output valid, output success, output letter_out,
                    output pairs_in_use, input ready);
    modport sink   (input valid, input success, input letter_out,
                    input pairs_in_use, output ready);
endinterface

### hw/rtl/plpt_cell.sv
// ---------------------------------------------------------------------------
// Plugboard pair cell
// Holds one letter pair, compares it against the item, and appends, keeps or
// takes the pair of the cell above when its own or a lower pair is deleted.
// ---------------------------------------------------------------------------
module plpt_cell
    import plpt_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_ctrl  i_ctrl,
    input  t_chain i_chain,
    output t_chain o_chain,
    input  t_slot  i_upper,
    output t_slot  o_slot
);

    logic    r_used;
    t_letter r_first;
    t_letter r_second;

    logic fa, fb, sa, sb;
    logic conflict_here;
    logic del_here;

    // compare the held pair with both letters of the item
    assign fa = (r_first  == i_ctrl.letter_a);
    assign fb = (r_first  == i_ctrl.letter_b);
    assign sa = (r_second == i_ctrl.letter_a);
    assign sb = (r_second == i_ctrl.letter_b);

    assign conflict_here = r_used & (fa | fb | sa | sb);
    assign del_here      = r_used & ((fa & sb) | (fb & sa));

    // pass match results up the chain; the lowest permute match wins
    always_comb begin
        o_chain.used        = r_used;
        o_chain.conflict    = i_chain.conflict | conflict_here;
        o_chain.del_seen    = i_chain.del_seen | del_here;
        o_chain.perm_found  = i_chain.perm_found;
        o_chain.perm_letter = i_chain.perm_letter;
        if (!i_chain.perm_found && r_used && fa) begin
            o_chain.perm_found  = 1'b1;
            o_chain.perm_letter = r_second;
        end else if (!i_chain.perm_found && r_used && sa) begin
            o_chain.perm_found  = 1'b1;
            o_chain.perm_letter = r_first;
        end
    end

    assign o_slot = '{used: r_used, first: r_first, second: r_second};

    // append into the lowest free cell, or shift down at and above a deleted pair
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used   <= 1'b0;
            r_first  <= EMPTY_MARK;
            r_second <= EMPTY_MARK;
        end else if (i_ctrl.add_en && !r_used && i_chain.used) begin
            r_used   <= 1'b1;
            r_first  <= i_ctrl.letter_a;
            r_second <= i_ctrl.letter_b;
        end else if (i_ctrl.del_en && (i_chain.del_seen || del_here)) begin
            r_used   <= i_upper.used;
            r_first  <= i_upper.first;
            r_second <= i_upper.second;
        end
    end

endmodule

### hw/rtl/plugboard_pair_table.sv
// ---------------------------------------------------------------------------
// Plugboard pair table
// Table of letter pairs with add, delete and permute actions.
// ---------------------------------------------------------------------------
// The table is a row of MAX_PAIRS cells, one pair each. Every item is
// resolved in the cycle it is accepted: all cells compare at once, match
// flags ripple up the row, and on a delete the cells above the match take
// their upper neighbor's pair. The result is registered, and one item is
// taken every cycle while the result side keeps up; the row of comparators
// and the ripple through MAX_PAIRS cells set the cycle time. No clearing
// pass is needed after reset.
module plugboard_pair_table
    import plpt_pkg::*;
#(
    parameter int MAX_PAIRS = 10
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    plpt_in_if.sink     i_in,
    plpt_out_if.source  o_out
);

    t_chain w_chain [MAX_PAIRS+1];
    t_slot  w_slot  [MAX_PAIRS+1];
    logic [MAX_PAIRS-1:0] w_used;

    t_ctrl  ctrl;
    logic   accept;
    logic   full;
    logic   add_ok;
    logic   del_ok;
    logic   is_perm;

    logic [COUNT_W-1:0]  r_count;
    logic [COUNT_W-1:0]  n_count;
    logic                r_out_valid;
    logic                r_success;
    logic [LETTER_W-1:0] r_letter_out;
    logic [COUNT_W-1:0]  r_pairs_in_use;

    // take an item whenever the result register is free or being drained
    assign i_in.ready = !r_out_valid || o_out.ready;
    assign accept     = i_in.valid && i_in.ready;

    // decide the action from the top of the chain
    assign full    = (r_count >= COUNT_W'(MAX_PAIRS));
    assign add_ok  = accept && (i_in.action == ACT_ADD) && !full &&
                     (i_in.letter_a != i_in.letter_b) && !w_chain[MAX_PAIRS].conflict;
    assign del_ok  = accept && (i_in.action == ACT_DEL) && w_chain[MAX_PAIRS].del_seen;
    assign is_perm = (i_in.action == ACT_PERM);

    assign ctrl = '{add_en: add_ok, del_en: del_ok,
                    letter_a: i_in.letter_a, letter_b: i_in.letter_b};

    // bottom of the chain: nothing matched yet, permute passes the letter
    assign w_chain[0] = '{used: 1'b1, conflict: 1'b0, del_seen: 1'b0,
                          perm_found: 1'b0, perm_letter: i_in.letter_a};
    // above the top cell there is only an empty slot
    assign w_slot[MAX_PAIRS] = '{used: 1'b0, first: EMPTY_MARK, second: EMPTY_MARK};

    for (genvar g = 0; g < MAX_PAIRS; g++) begin : g_cell
        plpt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctrl  (ctrl),
            .i_chain (w_chain[g]),
            .o_chain (w_chain[g+1]),
            .i_upper (w_slot[g+1]),
            .o_slot  (w_slot[g])
        );
        assign w_used[g] = w_slot[g].used;
    end

    // count after this action
    always_comb begin
        n_count = r_count;
        if (add_ok) begin
            n_count = r_count + COUNT_W'(1);
        end else if (del_ok) begin
            n_count = r_count - COUNT_W'(1);
        end
    end

    // hold the count and the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (accept) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_success      <= add_ok || del_ok || is_perm;
            r_letter_out   <= is_perm ? w_chain[MAX_PAIRS].perm_letter : '0;
            r_pairs_in_use <= n_count;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.success      = r_success;
    assign o_out.letter_out   = r_letter_out;
    assign o_out.pairs_in_use = r_pairs_in_use;

    // count never passes the table size
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= COUNT_W'(MAX_PAIRS))
        else $error("pair count above table size");

    // occupied cells match the count
    a_used_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(w_used) == int'(r_count))
        else $error("occupied cells disagree with pair count");

    // a successful add grows the table by one
    a_add_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        add_ok |=> (r_count == $past(r_count) + COUNT_W'(1)))
        else $error("add did not grow pair count");

    // occupied cells stay packed from the bottom
    a_packed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((w_used & (w_used + MAX_PAIRS'(1))) == '0))
        else $error("occupied cells not contiguous");

endmodule

### tb/plpt_checker.sv
// ---------------------------------------------------------------------------
// Plugboard pair table checker
// Watches both channels, keeps its own copy of the pair table, and works out
// the result of every accepted action item. It compares each returned result
// field by field with the oldest outstanding prediction and counts failures.
// ---------------------------------------------------------------------------
module plpt_checker
    import plpt_pkg::*;
#(
    parameter int MAX_PAIRS = 10
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    plpt_in_if    i_in,
    plpt_out_if   i_out,
    input  logic  i_end_check,
    output int    o_fail_count,
    output int    o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic               success;
        t_letter            letter_out;
        logic [COUNT_W-1:0] pairs_in_use;
    } t_outcome;

    // shadow pair table
    t_letter            first_tab [MAX_PAIRS];
    t_letter            second_tab[MAX_PAIRS];
    int                 held;

    t_outcome           outcome_q[$];
    int                 actions_seen;
    int                 results_seen;
    bit                 end_done;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        actions_seen = 0;
        results_seen = 0;
        end_done     = 1'b0;
        clear_table();
    end

    task automatic report_mismatch(input string msg);
        $display("ERROR @%0t: result %0d: %s", $realtime, results_seen, msg);
        o_fail_count++;
    endtask

    function automatic void clear_table();
        int i;
        for (i = 0; i < MAX_PAIRS; i++) begin
            first_tab[i]  = EMPTY_MARK;
            second_tab[i] = EMPTY_MARK;
        end
        held = 0;
    endfunction

    // Apply one action to the shadow table and return what the block must answer
    function automatic t_outcome table_step(input logic [1:0] act, input t_letter a,
                                            input t_letter b);
        t_outcome r;
        int       i;
        int       j;
        int       hit;
        bit       found;
        r     = '0;
        hit   = -1;
        found = 1'b0;
        case (act)
            ACT_ADD: begin
                found = (held >= MAX_PAIRS) || (a == b);
                for (i = 0; i < held; i++) begin
                    if (first_tab[i] == a || first_tab[i] == b ||
                        second_tab[i] == a || second_tab[i] == b)
                        found = 1'b1;
                end
                if (!found) begin
                    first_tab[held]  = a;
                    second_tab[held] = b;
                    held++;
                    r.success = 1'b1;
                end
            end
            ACT_DEL: begin
                for (i = 0; i < held; i++) begin
                    if (hit < 0 && ((first_tab[i] == a && second_tab[i] == b) ||
                                    (first_tab[i] == b && second_tab[i] == a)))
                        hit = i;
                end
                if (hit >= 0) begin
                    // close the gap and free the top slot
                    for (j = hit; j + 1 < held; j++) begin
                        first_tab[j]  = first_tab[j+1];
                        second_tab[j] = second_tab[j+1];
                    end
                    first_tab[held-1]  = EMPTY_MARK;
                    second_tab[held-1] = EMPTY_MARK;
                    held--;
                    r.success = 1'b1;
                end
            end
            ACT_PERM: begin
                r.success    = 1'b1;
                r.letter_out = a;
                // first slot wins, first letter tested before second
                for (i = 0; i < held; i++) begin
                    if (!found && first_tab[i] == a) begin
                        r.letter_out = second_tab[i];
                        found        = 1'b1;
                    end else if (!found && second_tab[i] == a) begin
                        r.letter_out = first_tab[i];
                        found        = 1'b1;
                    end
                end
            end
            default: begin
                // unused code: no change, no success
            end
        endcase
        r.pairs_in_use = held[COUNT_W-1:0];
        return r;
    endfunction

    // Compare returned results first, then predict the newly accepted action
    always @(posedge i_clk) begin
        t_outcome exp_r;
        if (i_rst_n) begin
            if (i_out.valid && i_out.ready) begin
                if (outcome_q.size() == 0) begin
                    report_mismatch("result with no action outstanding");
                end else begin
                    exp_r = outcome_q.pop_front();
                    if (i_out.success !== exp_r.success)
                        report_mismatch($sformatf("success got %b exp %b",
                                                  i_out.success, exp_r.success));
                    if (i_out.letter_out !== exp_r.letter_out)
                        report_mismatch($sformatf("letter_out got %h exp %h",
                                                  i_out.letter_out, exp_r.letter_out));
                    if (i_out.pairs_in_use !== exp_r.pairs_in_use)
                        report_mismatch($sformatf("pairs_in_use got %0d exp %0d",
                                                  i_out.pairs_in_use, exp_r.pairs_in_use));
                end
                results_seen++;
            end
            if (i_in.valid && i_in.ready) begin
                outcome_q.push_back(table_step(i_in.action, i_in.letter_a, i_in.letter_b));
                actions_seen++;
            end
            if (i_end_check && !end_done) begin
                if (outcome_q.size() != 0)
                    report_mismatch($sformatf("%0d results never returned",
                                              outcome_q.size()));
                end_done = 1'b1;
            end
            o_pending = outcome_q.size();
        end
    end

endmodule

### tb/tb.sv
// ---------------------------------------------------------------------------
// Plugboard pair table testbench
// Drives add, delete and permute items into the pair table with random gaps
// and result-side stalls, including one long stall that backs the block up.
// A directed opening covers the corner cases; the random part mixes phases
// that fill and drain the table. The checker predicts and compares.
// ---------------------------------------------------------------------------
module tb;
    import plpt_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PAIRS      = 10;
    localparam int RAND_ITEMS = 1100;

    // action code the block leaves unused
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic end_check;
    int   fail_count;
    int   pending;

    bit   quiet;
    bit   hold_go;
    bit   hold_done;
    bit   squeeze;

    logic [15:0] recent_pairs[$];

    plpt_in_if  in_ch();
    plpt_out_if out_ch();

    plugboard_pair_table #(
        .MAX_PAIRS (PAIRS)
    ) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    plpt_checker #(
        .MAX_PAIRS (PAIRS)
    ) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (in_ch),
        .i_out        (out_ch),
        .i_end_check  (end_check),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always #5ns i_clk = ~i_clk;

    // Offer one item, idling first now and then, and hold until it is taken
    task automatic send_item(input logic [1:0] act, input t_letter a, input t_letter b);
        if (!quiet && !squeeze && $urandom_range(0, 4) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge i_clk);
        end
        in_ch.valid    <= 1'b1;
        in_ch.action   <= act;
        in_ch.letter_a <= a;
        in_ch.letter_b <= b;
        if (act == ACT_ADD) begin
            recent_pairs.push_back({a, b});
            if (recent_pairs.size() > 16)
                void'(recent_pairs.pop_front());
        end
        do @(posedge i_clk); while (!in_ch.ready);
    endtask

    // Mostly a small alphabet so pairs collide, sometimes any byte
    function automatic t_letter pick_letter();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 6)
            return EMPTY_MARK;
        else if (roll < 80)
            return t_letter'(8'h41 + $urandom_range(0, 21));
        else
            return t_letter'($urandom_range(0, 255));
    endfunction

    // Alternate fill-heavy and drain-heavy stretches of random actions
    task automatic random_item(input int idx);
        logic [1:0]  act;
        t_letter     a;
        t_letter     b;
        logic [15:0] pr;
        int          roll;
        int          add_w;
        int          del_w;
        roll  = $urandom_range(0, 99);
        add_w = ((idx / 100) % 2 == 0) ? 55 : 20;
        del_w = ((idx / 100) % 2 == 0) ? 15 : 45;
        a     = pick_letter();
        b     = pick_letter();
        if (roll < 4)
            act = ACT_UNUSED;
        else if (roll < 4 + add_w)
            act = ACT_ADD;
        else if (roll < 4 + add_w + del_w)
            act = ACT_DEL;
        else
            act = ACT_PERM;
        if (act == ACT_PERM)
            b = t_letter'($urandom_range(0, 255));
        if (act == ACT_DEL && recent_pairs.size() != 0 && $urandom_range(0, 9) < 8) begin
            pr = recent_pairs[$urandom_range(0, recent_pairs.size() - 1)];
            if ($urandom_range(0, 1) == 0) begin
                a = pr[15:8];
                b = pr[7:0];
            end else begin
                a = pr[7:0];
                b = pr[15:8];
            end
        end
        send_item(act, a, b);
    endtask

    // Result side: random stalls, one long hold-off, none near the end
    initial begin
        out_ch.ready <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        out_ch.ready <= 1'b1;
        forever begin
            @(posedge i_clk);
            if (hold_go && !hold_done) begin
                squeeze = 1'b1;
                out_ch.ready <= 1'b0;
                repeat (60) @(posedge i_clk);
                out_ch.ready <= 1'b1;
                squeeze   = 1'b0;
                hold_done = 1'b1;
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge i_clk);
                out_ch.ready <= 1'b1;
            end
        end
    end

    // Stimulus and verdict
    initial begin
        int k;
        int guard;
        quiet     = 1'b0;
        hold_go   = 1'b0;
        hold_done = 1'b0;
        squeeze   = 1'b0;
        end_check      <= 1'b0;
        i_rst_n        <= 1'b0;
        in_ch.valid    <= 1'b0;
        in_ch.action   <= ACT_ADD;
        in_ch.letter_a <= '0;
        in_ch.letter_b <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // permute and delete on an empty table
        send_item(ACT_PERM, EMPTY_MARK, 8'hFF);
        send_item(ACT_DEL, 8'h41, 8'h42);
        // refused add of equal letters, one accepted add, then refused adds of a letter already paired
        send_item(ACT_ADD, 8'h41, 8'h41);
        send_item(ACT_ADD, 8'h41, 8'h42);
        send_item(ACT_ADD, 8'h42, 8'h43);
        send_item(ACT_ADD, 8'h43, 8'h41);
        // the empty marker is an ordinary letter
        send_item(ACT_ADD, EMPTY_MARK, 8'hFF);
        send_item(ACT_PERM, EMPTY_MARK, 8'h00);
        send_item(ACT_PERM, 8'hFF, 8'hAA);
        send_item(ACT_PERM, 8'h00, 8'h55);
        send_item(ACT_PERM, 8'h42, 8'h00);
        // unused action code
        send_item(ACT_UNUSED, 8'h41, 8'h42);
        // fill the table, then try one more
        for (k = 0; k < 8; k++)
            send_item(ACT_ADD, t_letter'(8'h43 + 2 * k), t_letter'(8'h44 + 2 * k));
        send_item(ACT_ADD, 8'h59, 8'h5A);
        // delete in reversed order, from the middle, and one not held
        send_item(ACT_DEL, 8'h42, 8'h41);
        send_item(ACT_PERM, 8'h41, 8'hFF);
        send_item(ACT_DEL, 8'h46, 8'h45);
        send_item(ACT_DEL, 8'h45, 8'h47);
        send_item(ACT_ADD, 8'h80, 8'h7F);
        send_item(ACT_PERM, 8'h7F, 8'h00);

        for (k = 0; k < RAND_ITEMS; k++) begin
            quiet = (k >= 450 && k < 600) || (k >= RAND_ITEMS - 150);
            if (k == 200)
                hold_go = 1'b1;
            random_item(k);
        end
        in_ch.valid <= 1'b0;

        // drain, then let the last result settle
        guard = 0;
        while (pending != 0 && guard < 2000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (4) @(posedge i_clk);
        end_check <= 1'b1;
        repeat (3) @(posedge i_clk);
        if (fail_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Watchdog
    initial begin
        #2ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

### filelist.f
hw/rtl/plpt_pkg.sv
hw/rtl/plpt_ifs.sv
hw/rtl/plpt_cell.sv
hw/rtl/plugboard_pair_table.sv
tb/plpt_checker.sv
tb/tb.sv
